/* design/ttio_pkg.sv */
package ttio_pkg;

	// Default sizes
	localparam int LINE_CHARS_DEF  = 64;
	localparam int STORE_CHARS_DEF = 2048;
	localparam int KEY_DEPTH_DEF   = 1024;

	// Stream widths
	localparam int IN_TDATA_W  = 32;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 16;
	localparam int FIDX_W      = 11;

	// Item kinds
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_KEY   = 2'd2;
	localparam logic [1:0] KIND_FETCH = 2'd3;

	// Port numbers
	localparam logic [7:0] PORT_MODE = 8'd1;
	localparam logic [7:0] PORT_OP   = 8'd2;
	localparam logic [7:0] PORT_TEXT = 8'd3;
	localparam logic [7:0] PORT_KEY  = 8'd4;
	localparam logic [7:0] PORT_BANK = 8'd10;

	// Text operation codes
	localparam logic [7:0] OP_APPEND  = 8'd0;
	localparam logic [7:0] OP_DELETE  = 8'd1;
	localparam logic [7:0] OP_NEWLINE = 8'd2;
	localparam logic [7:0] OP_CLEAR   = 8'd3;

	// Character codes
	localparam logic [7:0] FILL_CODE  = 8'd95;
	localparam logic [7:0] ASCII_MASK = 8'h7F;
	localparam logic [7:0] CHAR_BASE  = 8'd32;
	localparam logic [2:0] BANK_MASK  = 3'b111;

	// Controller to datapath
	typedef struct packed {
		logic take;
		logic exec;
		logic del_rd;
		logic del_wr;
		logic nl_step;
		logic clr_step;
		logic wipe;
		logic finish;
	} ttio_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic wipe_last;
		logic del_start;
		logic nl_start;
		logic nl_last;
		logic clr_start;
		logic cursor_zero;
		logic del_more;
		logic out_free;
	} ttio_sts_t;

endpackage

/* design/ttio_ram.sv */
module ttio_ram import ttio_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

/* design/ttio_ctrl.sv */
module ttio_ctrl import ttio_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ttio_sts_t sts,
	output ttio_cmd_t cmd
);

	localparam logic [2:0] ST_WIPE   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_EXEC   = 3'd2;
	localparam logic [2:0] ST_DEL_RD = 3'd3;
	localparam logic [2:0] ST_DEL_WR = 3'd4;
	localparam logic [2:0] ST_NL     = 3'd5;
	localparam logic [2:0] ST_CLR    = 3'd6;
	localparam logic [2:0] ST_DONE   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_WIPE: begin
				cmd.wipe = 1'b1;
				if (sts.wipe_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				priority if (sts.del_start) begin
					state_d = ST_DEL_RD;
				end else if (sts.nl_start) begin
					state_d = sts.nl_last ? ST_DONE : ST_NL;
				end else if (sts.clr_start) begin
					state_d = ST_CLR;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DEL_RD: begin
				cmd.del_rd = 1'b1;
				state_d    = ST_DEL_WR;
			end
			ST_DEL_WR: begin
				cmd.del_wr = 1'b1;
				state_d    = sts.del_more ? ST_DEL_RD : ST_DONE;
			end
			ST_NL: begin
				cmd.nl_step = 1'b1;
				if (sts.nl_last) state_d = ST_DONE;
			end
			ST_CLR: begin
				if (sts.cursor_zero) begin
					state_d = ST_DONE;
				end else begin
					cmd.clr_step = 1'b1;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WIPE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* design/ttio_dp.sv */
module ttio_dp import ttio_pkg::*; #(
	parameter int LINE_CHARS  = LINE_CHARS_DEF,
	parameter int STORE_CHARS = STORE_CHARS_DEF,
	parameter int KEY_DEPTH   = KEY_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ttio_cmd_t        cmd,
	output ttio_sts_t        sts,
	input  logic [1:0]       in_kind,
	input  logic [7:0]       in_port,
	input  logic [7:0]       in_data,
	input  logic [FIDX_W-1:0] in_fidx,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [7:0]       out_read_data,
	output logic             out_dirty
);

	localparam int AW    = $clog2(STORE_CHARS);
	localparam int KW    = $clog2(KEY_DEPTH);
	localparam int CW    = $clog2(LINE_CHARS);
	localparam int CUR_W = $clog2(STORE_CHARS + LINE_CHARS + 1);
	localparam logic [CW-1:0]    COL_LAST  = CW'(LINE_CHARS - 1);
	localparam logic [CW-1:0]    STORE_COL = CW'(STORE_CHARS % LINE_CHARS);
	localparam logic [CUR_W-1:0] CUR_MAX   = CUR_W'(STORE_CHARS);
	localparam logic [KW-1:0]    KEY_LAST  = KW'(KEY_DEPTH - 1);

	// Item registers
	logic [1:0]        kind_q;
	logic [7:0]        port_q;
	logic [7:0]        data_q;
	logic [FIDX_W-1:0] fidx_q;

	// Architectural state
	logic [7:0]       mode_q;
	logic [7:0]       op_q;
	logic [CUR_W-1:0] cursor_q;
	logic [CW-1:0]    col_q;
	logic             dirty_q;
	logic [KW-1:0]    key_wr_q;
	logic [KW-1:0]    key_rd_q;
	logic [2:0]       bank_q;
	logic [AW-1:0]    wipe_q;

	// Output register
	logic       out_valid_q;
	logic [7:0] out_rd_q;
	logic       out_dirty_q;

	logic             is_wr, is_rd, is_text, in_store;
	logic             do_append, nl_adv;
	logic [CUR_W-1:0] cursor_p1, cursor_m1;
	logic [CW-1:0]    col_p1, col_m1;
	logic [KW-1:0]    key_wr_nx, key_rd_nx;
	logic             key_full, key_empty, fetch_ok;
	logic [2:0]       bank_wr;

	logic          cram_we;
	logic [AW-1:0] cram_waddr, cram_raddr;
	logic [7:0]    cram_wdata, cram_rdata;
	logic          kram_we;
	logic [7:0]    kram_rdata;
	logic [7:0]    result;

	// Decode
	assign is_wr     = (kind_q == KIND_WRITE);
	assign is_rd     = (kind_q == KIND_READ);
	assign is_text   = (is_wr || is_rd) && (port_q == PORT_TEXT);
	assign in_store  = (cursor_q < CUR_MAX);
	assign cursor_p1 = cursor_q + CUR_W'(1);
	assign cursor_m1 = cursor_q - CUR_W'(1);
	assign col_p1    = (col_q == COL_LAST) ? '0 : col_q + CW'(1);
	assign col_m1    = (col_q == '0) ? COL_LAST : col_q - CW'(1);
	assign do_append = cmd.exec && is_text && is_wr && (op_q == OP_APPEND) && in_store;
	assign nl_adv    = (cmd.exec && is_text && (op_q == OP_NEWLINE)) || cmd.nl_step;
	assign key_wr_nx = (key_wr_q == KEY_LAST) ? '0 : key_wr_q + KW'(1);
	assign key_rd_nx = (key_rd_q == KEY_LAST) ? '0 : key_rd_q + KW'(1);
	assign key_full  = (key_wr_nx == key_rd_q);
	assign key_empty = (key_wr_q == key_rd_q);
	assign fetch_ok  = ({1'b0, fidx_q} < (FIDX_W + 1)'(STORE_CHARS));
	assign bank_wr   = data_q[2:0] & BANK_MASK;

	// Status
	assign sts.wipe_last   = (wipe_q == AW'(STORE_CHARS - 1));
	assign sts.del_start   = is_text && (op_q == OP_DELETE) && (cursor_q != '0);
	assign sts.nl_start    = is_text && (op_q == OP_NEWLINE);
	assign sts.nl_last     = (col_q == COL_LAST);
	assign sts.clr_start   = is_text && (op_q == OP_CLEAR);
	assign sts.cursor_zero = (cursor_q == '0);
	assign sts.del_more    = (cram_rdata == FILL_CODE) && (cursor_q != '0);
	assign sts.out_free    = !out_valid_q || out_ready;

	// Character store write port
	always_comb begin
		cram_we    = 1'b0;
		cram_waddr = cursor_q[AW-1:0];
		cram_wdata = '0;
		priority if (cmd.wipe) begin
			cram_we    = 1'b1;
			cram_waddr = wipe_q;
		end else if (do_append) begin
			cram_we    = 1'b1;
			cram_wdata = (data_q & ASCII_MASK) - CHAR_BASE;
		end else if (nl_adv) begin
			// first pad position gets 0, the rest the fill code
			cram_we    = in_store;
			cram_wdata = cmd.exec ? 8'd0 : FILL_CODE;
		end else if (cmd.del_wr) begin
			cram_we = 1'b1;
		end else if (cmd.clr_step) begin
			cram_we    = 1'b1;
			cram_waddr = cursor_m1[AW-1:0];
		end else begin
			cram_we = 1'b0;
		end
	end

	assign cram_raddr = cmd.del_rd ? cursor_m1[AW-1:0] : fidx_q[AW-1:0];

	ttio_ram #(.WIDTH(8), .DEPTH(STORE_CHARS)) u_char_ram (
		.clk     (clk),
		.wr_en   (cram_we),
		.wr_addr (cram_waddr),
		.wr_data (cram_wdata),
		.rd_addr (cram_raddr),
		.rd_data (cram_rdata)
	);

	// Keyboard ring
	assign kram_we = cmd.exec && (kind_q == KIND_KEY) && !key_full;

	ttio_ram #(.WIDTH(8), .DEPTH(KEY_DEPTH)) u_key_ram (
		.clk     (clk),
		.wr_en   (kram_we),
		.wr_addr (key_wr_q),
		.wr_data (data_q),
		.rd_addr (key_rd_q),
		.rd_data (kram_rdata)
	);

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			kind_q <= in_kind;
			port_q <= in_port;
			data_q <= in_data;
			fidx_q <= in_fidx;
		end
	end

	// Result select
	always_comb begin
		result = '0;
		unique case (kind_q)
			KIND_READ: begin
				priority if (port_q == PORT_MODE) begin
					result = mode_q;
				end else if (port_q == PORT_OP) begin
					result = op_q;
				end else if (port_q == PORT_KEY) begin
					result = key_empty ? 8'd0 : kram_rdata;
				end else if (port_q == PORT_BANK) begin
					result = {5'd0, bank_q};
				end else begin
					result = '0;
				end
			end
			KIND_FETCH: result = fetch_ok ? cram_rdata : 8'd0;
			default:    result = '0;
		endcase
	end

	// Registers, pointers and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= '0;
			op_q     <= '0;
			cursor_q <= '0;
			col_q    <= '0;
			dirty_q  <= 1'b0;
			key_wr_q <= '0;
			key_rd_q <= '0;
			bank_q   <= 3'd1;
			wipe_q   <= '0;
		end else begin
			if (cmd.wipe) wipe_q <= wipe_q + AW'(1);
			if (cmd.exec) begin
				if (is_text) dirty_q <= 1'b1;
				if (is_wr && port_q == PORT_MODE) begin
					mode_q  <= data_q;
					dirty_q <= 1'b1;
				end
				if (is_wr && port_q == PORT_OP) op_q <= data_q;
				if (is_wr && port_q == PORT_BANK) bank_q <= (bank_wr == '0) ? 3'd1 : bank_wr;
				if (kind_q == KIND_FETCH) dirty_q <= 1'b0;
				if (kram_we) key_wr_q <= key_wr_nx;
				if (sts.clr_start) col_q <= '0;
			end
			if (do_append) begin
				cursor_q <= cursor_p1;
				col_q    <= col_p1;
			end
			// newline walk: clamp to capacity at the line end
			if (nl_adv) begin
				if (col_q == COL_LAST && cursor_p1 > CUR_MAX) begin
					cursor_q <= CUR_MAX;
					col_q    <= STORE_COL;
				end else begin
					cursor_q <= cursor_p1;
					col_q    <= col_p1;
				end
			end
			if (cmd.del_rd) begin
				cursor_q <= cursor_m1;
				col_q    <= col_m1;
			end
			if (cmd.clr_step) cursor_q <= cursor_m1;
			if (cmd.finish && is_rd && port_q == PORT_KEY && !key_empty) key_rd_q <= key_rd_nx;
		end
	end

	// Output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_rd_q    <= result;
			out_dirty_q <= dirty_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_read_data = out_rd_q;
	assign out_dirty     = out_dirty_q;

endmodule

/* design/text_terminal_io_ports.sv */
// Channel   Dir  Beat fields (lowest bit up)
// s_axis    in   tuser: kind[1:0]; tdata: port[7:0], data[15:8], fetch_index[26:16]
// m_axis    out  tdata: read_data[7:0], dirty[8]
//
// A port access, key arrival or display fetch loads the output register through the exec
// and done states after accept; the next beat can be taken once it is loaded, even while
// a result waits. Delete takes a read and a write step per cleared entry, new line a step
// per position after the first up to the line end, clear a step per entry below the
// cursor, all on the one store port. After reset the character store is zeroed, no beat
// taken. A stalled output holds the block in its last step until the beat is taken.
module text_terminal_io_ports import ttio_pkg::*; #(
	parameter int LINE_CHARS  = LINE_CHARS_DEF,
	parameter int STORE_CHARS = STORE_CHARS_DEF,
	parameter int KEY_DEPTH   = KEY_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // port, data, fetch_index
	input  logic [IN_TUSER_W-1:0]  s_axis_tuser,  // kind
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // read_data, dirty
);

	ttio_cmd_t  cmd;
	ttio_sts_t  sts;
	logic [7:0] rd_data;
	logic       dirty;

	ttio_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ttio_dp #(
		.LINE_CHARS  (LINE_CHARS),
		.STORE_CHARS (STORE_CHARS),
		.KEY_DEPTH   (KEY_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_kind       (s_axis_tuser[1:0]),
		.in_port       (s_axis_tdata[7:0]),
		.in_data       (s_axis_tdata[15:8]),
		.in_fidx       (s_axis_tdata[16 +: FIDX_W]),
		.out_ready     (m_axis_tready),
		.out_valid     (m_axis_tvalid),
		.out_read_data (rd_data),
		.out_dirty     (dirty)
	);

	assign m_axis_tdata = {7'd0, dirty, rd_data};

endmodule

/* design/ttio_checker.sv */
module ttio_checker import ttio_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready
);

	logic       s_beat, m_beat;
	logic [1:0] pend_q;

	assign s_beat = s_axis_tvalid && s_axis_tready;
	assign m_beat = m_axis_tvalid && m_axis_tready;

	// Beats taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(s_beat) - 2'(m_beat);
		end
	end

	// Stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output beat changed under stall");

	// One item at a time: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_beat |=> !s_axis_tready)
		else $error("input accepted while an item is in work");

	// No result without an item, at most one waiting plus one in work
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pend_q != 2'd0)
		else $error("result shown with no item outstanding");

	a_pend_max: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many items outstanding");

	// Padding bits of the result stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15:9] == 7'd0)
		else $error("result padding not zero");

endmodule

bind text_terminal_io_ports ttio_checker u_ttio_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);

/* tb/testbench.sv */
module testbench import ttio_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE        = LINE_CHARS_DEF;
	localparam int STORE       = STORE_CHARS_DEF;
	localparam int KEYS        = KEY_DEPTH_DEF;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 25000;
	localparam int TAIL_CYCLES = 20;
	localparam logic [7:0] OP_UNUSED = 8'hC8;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  port;
		logic [7:0]  data;
		logic [10:0] fidx;
	} io_item_t;

	typedef struct packed {
		logic [7:0] rd;
		logic       dirty;
	} io_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;  // port, data, fetch_index
	logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;  // kind
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;       // read_data, dirty

	// Predicted port block state
	logic [7:0]  disp_mode;
	logic [7:0]  text_op;
	int unsigned cur_pos;
	logic [7:0]  char_mem [STORE];
	logic        scr_dirty;
	logic [7:0]  key_mem [KEYS];
	int unsigned key_wr;
	int unsigned key_rd;
	logic [2:0]  bank_reg;

	io_result_t  read_dirty_q [$];
	bit          tx_gaps, rx_gaps, hold_req;
	int unsigned rx_wait;
	int unsigned beats_sent, results_seen, keys_dropped, peak_cursor;
	int unsigned fail_count, quiet_cycles;

	text_terminal_io_ports dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Random helpers
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [10:0] rand_fidx();
		return 11'($urandom_range(0, STORE - 1));
	endfunction

	function automatic logic [10:0] fidx_near_cursor();
		return 11'($urandom_range(0, (cur_pos < STORE) ? cur_pos : STORE - 1));
	endfunction

	function automatic logic [7:0] rand_op();
		if ($urandom_range(0, 9) == 0)
			return rand_byte();
		case ($urandom_range(0, 3))
			0: return OP_APPEND;
			1: return OP_DELETE;
			2: return OP_NEWLINE;
			default: return OP_CLEAR;
		endcase
	endfunction

	function automatic logic [7:0] rand_port();
		if ($urandom_range(0, 9) < 3)
			return rand_byte();
		case ($urandom_range(0, 4))
			0: return PORT_MODE;
			1: return PORT_OP;
			2: return PORT_TEXT;
			3: return PORT_KEY;
			default: return PORT_BANK;
		endcase
	endfunction

	function automatic logic [1:0] rand_kind();
		case ($urandom_range(0, 3))
			0: return KIND_WRITE;
			1: return KIND_READ;
			2: return KIND_KEY;
			default: return KIND_FETCH;
		endcase
	endfunction

	// Text codes that append the fill code (0x7F, 0xFF) show up often
	function automatic logic [7:0] rand_char();
		if ($urandom_range(0, 6) == 0)
			return $urandom_range(0, 1) ? 8'hFF : 8'h7F;
		return rand_byte();
	endfunction

	// Predictor
	function automatic void clear_state();
		disp_mode = '0;
		text_op   = OP_APPEND;
		cur_pos   = 0;
		scr_dirty = 1'b0;
		key_wr    = 0;
		key_rd    = 0;
		bank_reg  = 3'd1;
		for (int i = 0; i < STORE; i++)
			char_mem[i] = '0;
	endfunction

	// Port 3 access: apply the current text operation to the store
	function automatic void text_access(input bit is_wr, input logic [7:0] d);
		logic [7:0]  prev;
		int unsigned pad;
		scr_dirty = 1'b1;
		case (text_op)
			OP_APPEND: begin
				if (is_wr && cur_pos < STORE) begin
					char_mem[cur_pos] = (d & ASCII_MASK) - CHAR_BASE;
					cur_pos++;
				end
			end
			OP_DELETE: begin
				// step back over fill padding until a real entry is cleared
				if (cur_pos != 0) begin
					do begin
						cur_pos--;
						prev = '0;
						if (cur_pos < STORE) begin
							prev = char_mem[cur_pos];
							char_mem[cur_pos] = '0;
						end
					end while (prev == FILL_CODE && cur_pos > 0);
				end
			end
			OP_NEWLINE: begin
				pad = LINE - (cur_pos % LINE);
				for (int i = 0; i < pad; i++)
					if (cur_pos + i < STORE)
						char_mem[cur_pos + i] = FILL_CODE;
				if (cur_pos < STORE)
					char_mem[cur_pos] = '0;
				cur_pos = cur_pos + pad;
				if (cur_pos > STORE)
					cur_pos = STORE;
			end
			OP_CLEAR: begin
				for (int i = 0; i < cur_pos && i < STORE; i++)
					char_mem[i] = '0;
				cur_pos = 0;
			end
			default: ;
		endcase
		if (cur_pos > peak_cursor)
			peak_cursor = cur_pos;
	endfunction

	function automatic io_result_t io_step(input io_item_t it);
		logic [7:0]  rd;
		int unsigned nxt;
		rd = '0;
		case (it.kind)
			KIND_WRITE: begin
				case (it.port)
					PORT_MODE: begin
						scr_dirty = 1'b1;
						disp_mode = it.data;
					end
					PORT_OP:   text_op = it.data;
					PORT_TEXT: text_access(1'b1, it.data);
					PORT_BANK: begin
						bank_reg = it.data[2:0] & BANK_MASK;
						if (bank_reg == '0)
							bank_reg = 3'd1;
					end
					default: ;
				endcase
			end
			KIND_READ: begin
				case (it.port)
					PORT_MODE: rd = disp_mode;
					PORT_OP:   rd = text_op;
					PORT_TEXT: text_access(1'b0, it.data);
					PORT_KEY: begin
						if (key_rd != key_wr) begin
							rd = key_mem[key_rd];
							key_rd = (key_rd + 1) % KEYS;
						end
					end
					PORT_BANK: rd = {5'b0, bank_reg};
					default: ;
				endcase
			end
			KIND_KEY: begin
				nxt = (key_wr + 1) % KEYS;
				if (nxt != key_rd) begin
					key_mem[key_wr] = it.data;
					key_wr = nxt;
				end else
					keys_dropped++;
			end
			default: begin
				if (it.fidx < STORE)
					rd = char_mem[it.fidx];
				scr_dirty = 1'b0;
			end
		endcase
		return '{rd: rd, dirty: scr_dirty};
	endfunction

	// Sender: one beat per call, entered and left at a falling edge
	task automatic send_beat(input logic [1:0] kind, input logic [7:0] port,
		input logic [7:0] data, input logic [10:0] fidx);
		io_item_t    item;
		int unsigned gap;
		item = '{kind: kind, port: port, data: data, fidx: fidx};
		gap = tx_gaps ? idle_len() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= item.kind;
		s_axis_tdata  <= {5'b0, item.fidx, item.data, item.port};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		read_dirty_q.push_back(io_step(item));
		beats_sent++;
	endtask

	// Receiver: random stalls, plus one long hold on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			rx_wait = HOLD_CYCLES;
		end
		if (rx_wait > 0) begin
			rx_wait--;
			m_axis_tready <= 1'b0;
		end else if (rx_gaps) begin
			rx_wait = idle_len();
			if (rx_wait > 0) begin
				rx_wait--;
				m_axis_tready <= 1'b0;
			end else
				m_axis_tready <= 1'b1;
		end else
			m_axis_tready <= 1'b1;
	end

	// Result checker
	always @(posedge clk) begin : check_results
		io_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (read_dirty_q.size() == 0) begin
				$error("result beat with nothing expected: tdata %0h", m_axis_tdata);
				fail_count++;
			end else begin
				want = read_dirty_q.pop_front();
				if (m_axis_tdata[7:0] !== want.rd) begin
					$error("read_data: expected %0h, got %0h", want.rd, m_axis_tdata[7:0]);
					fail_count++;
				end
				if (m_axis_tdata[8] !== want.dirty) begin
					$error("dirty: expected %0b, got %0b", want.dirty, m_axis_tdata[8]);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: too long with no beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout after %0d idle cycles", quiet_cycles);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Reset values, bank mapping, unhandled ports, a couple of keys
	task automatic test_port_registers();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		send_beat(KIND_READ, PORT_OP, 8'h00, 11'd0);
		send_beat(KIND_READ, PORT_KEY, 8'hFF, 11'd0);
		send_beat(KIND_WRITE, PORT_BANK, 8'h00, 11'd0);
		send_beat(KIND_READ, PORT_BANK, 8'h00, 11'd0);
		send_beat(KIND_WRITE, PORT_MODE, 8'hFF, 11'd0);
		send_beat(KIND_READ, PORT_MODE, 8'h00, 11'd0);
		send_beat(KIND_WRITE, 8'hFF, 8'hAA, 11'h7FF);
		send_beat(KIND_KEY, 8'h00, 8'h00, 11'd0);
		send_beat(KIND_KEY, 8'hFF, 8'hFF, 11'd0);
		send_beat(KIND_READ, PORT_KEY, 8'h00, 11'd0);
		send_beat(KIND_READ, PORT_KEY, 8'h00, 11'd0);
		send_beat(KIND_FETCH, 8'h00, 8'h00, 11'h7FF);
	endtask

	// Every text operation, delete walking back over padding, read-side ops
	task automatic test_text_ops();
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		send_beat(KIND_WRITE, PORT_OP, OP_APPEND, 11'd0);
		send_beat(KIND_WRITE, PORT_TEXT, 8'hFF, 11'd0);
		send_beat(KIND_WRITE, PORT_TEXT, 8'h41, 11'd0);
		send_beat(KIND_READ, PORT_TEXT, 8'h42, 11'd0);
		send_beat(KIND_WRITE, PORT_OP, OP_NEWLINE, 11'd0);
		send_beat(KIND_WRITE, PORT_TEXT, 8'h00, 11'd0);
		send_beat(KIND_WRITE, PORT_OP, OP_DELETE, 11'd0);
		send_beat(KIND_WRITE, PORT_TEXT, 8'h00, 11'd0);
		send_beat(KIND_READ, PORT_TEXT, 8'h00, 11'd0);
		send_beat(KIND_WRITE, PORT_TEXT, 8'h00, 11'd0);
		send_beat(KIND_WRITE, PORT_TEXT, 8'h00, 11'd0);
		send_beat(KIND_WRITE, PORT_OP, OP_UNUSED, 11'd0);
		send_beat(KIND_WRITE, PORT_TEXT, 8'h00, 11'd0);
		send_beat(KIND_WRITE, PORT_OP, OP_CLEAR, 11'd0);
		send_beat(KIND_WRITE, PORT_TEXT, 8'h00, 11'd0);
		send_beat(KIND_FETCH, 8'h00, 8'h00, 11'd0);
	endtask

	// Fill the store with new lines past its end, then delete and clear from there
	task automatic test_store_capacity();
		send_beat(KIND_WRITE, PORT_OP, OP_CLEAR, 11'd0);
		send_beat(KIND_WRITE, PORT_TEXT, 8'h00, 11'd0);
		send_beat(KIND_WRITE, PORT_OP, OP_NEWLINE, 11'd0);
		repeat (STORE / LINE + 1)
			send_beat(KIND_WRITE, PORT_TEXT, rand_byte(), rand_fidx());
		send_beat(KIND_READ, PORT_TEXT, 8'h00, 11'd0);
		send_beat(KIND_WRITE, PORT_OP, OP_APPEND, 11'd0);
		send_beat(KIND_WRITE, PORT_TEXT, 8'h41, 11'd0);
		send_beat(KIND_FETCH, 8'h00, 8'h00, 11'(STORE - 1));
		send_beat(KIND_FETCH, 8'h00, 8'h00, 11'(STORE - LINE));
		send_beat(KIND_WRITE, PORT_OP, OP_DELETE, 11'd0);
		send_beat(KIND_WRITE, PORT_TEXT, 8'h00, 11'd0);
		send_beat(KIND_FETCH, 8'h00, 8'h00, 11'(STORE - LINE + 1));
		send_beat(KIND_WRITE, PORT_OP, OP_CLEAR, 11'd0);
		send_beat(KIND_READ, PORT_TEXT, 8'h00, 11'd0);
		send_beat(KIND_FETCH, 8'h00, 8'h00, 11'd0);
	endtask

	// Mostly op-then-text bursts, plus key traffic, fetches and noise
	task automatic test_random_traffic(input int unsigned count);
		int unsigned done, next_mix, sel, len;
		done = 0;
		next_mix = 0;
		while (done < count) begin
			if (done >= next_mix) begin
				tx_gaps = ($urandom_range(0, 3) != 0);
				rx_gaps = ($urandom_range(0, 3) != 0);
				next_mix = done + 40;
			end
			sel = $urandom_range(0, 99);
			if (sel < 45) begin
				send_beat(KIND_WRITE, PORT_OP, rand_op(), rand_fidx());
				len = $urandom_range(1, 8);
				repeat (len)
					send_beat(($urandom_range(0, 4) == 0) ? KIND_READ : KIND_WRITE,
						PORT_TEXT, rand_char(), rand_fidx());
				done += len + 1;
			end else if (sel < 60) begin
				len = $urandom_range(1, 5);
				repeat (len)
					send_beat(KIND_KEY, rand_byte(), rand_byte(), rand_fidx());
				repeat ($urandom_range(1, 6)) begin
					send_beat(KIND_READ, PORT_KEY, rand_byte(), rand_fidx());
					done++;
				end
				done += len;
			end else if (sel < 75) begin
				send_beat(KIND_FETCH, rand_byte(), rand_byte(), fidx_near_cursor());
				done++;
			end else begin
				send_beat(rand_kind(), rand_port(), rand_byte(), rand_fidx());
				done++;
			end
		end
	endtask

	// Overfill the key ring, then pop and refill across the pointer wrap
	task automatic test_key_ring_full();
		tx_gaps = 1'b0;
		rx_gaps = 1'b1;
		repeat (KEYS + 6)
			send_beat(KIND_KEY, rand_byte(), rand_byte(), rand_fidx());
		repeat (10)
			send_beat(KIND_READ, PORT_KEY, rand_byte(), rand_fidx());
		tx_gaps = 1'b1;
		repeat (14)
			send_beat(KIND_KEY, rand_byte(), rand_byte(), rand_fidx());
		repeat (6)
			send_beat(KIND_READ, PORT_KEY, rand_byte(), rand_fidx());
	endtask

	// Receiver holds off while beats keep coming, so the input side backs up
	task automatic test_output_backpressure();
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		hold_req = 1'b1;
		repeat (40)
			send_beat(rand_kind(), rand_port(), rand_char(), fidx_near_cursor());
	endtask

	initial begin
		clear_state();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_port_registers();
		test_text_ops();
		test_store_capacity();
		test_random_traffic(300);
		test_key_ring_full();
		test_random_traffic(200);
		test_output_backpressure();

		// let everything drain, then keep the clock running for stray beats
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (read_dirty_q.size() != 0);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Sent %0d input beats, checked %0d result beats, %0d keys dropped on a full ring.",
			beats_sent, results_seen, keys_dropped);
		$display("Text ops reached cursor %0d (store end), with a %0d-cycle output hold.",
			peak_cursor, HOLD_CYCLES);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
